@@ design/stdf_pkg.sv @@
// Package for the sieve trial-division filter: widths, register indexes,
// reset values and the controller state type. No dependencies.
package stdf_pkg;

   localparam int MAX_LIMIT_DEF = 65535;
   localparam int CANDIDATE_W   = 32;
   localparam int CSR_DATA_W    = 16;
   localparam int CSR_INDEX_W   = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPPER_BOUND = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOWER_BOUND = 1'd1;

   localparam logic [CSR_DATA_W-1:0] UPPER_BOUND_RESET = 16'hFFFF;
   localparam logic [CSR_DATA_W-1:0] LOWER_BOUND_RESET = 16'd2;
   localparam logic [CSR_DATA_W-1:0] MIN_DIVISOR       = 16'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_SIEVE_RD,
      ST_SIEVE_CHK,
      ST_MARK,
      ST_TEST_RD,
      ST_TEST_CHK,
      ST_DIV
   } stdf_state_type;

endpackage

@@ design/stdf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module stdf_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sieve_trial_division_filter_top.sv @@
// Top level of the sieve trial-division filter: controller, sieve builder and
// bit-serial remainder unit around one bitmap RAM. Uses stdf_pkg and stdf_ram.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ----------------------------
//  request   req_candidate_value                     start && !busy
//  result    rsp_passes_filter                       rsp_valid, one-cycle strobe
//  config    csr_index, csr_write_data               csr_write_enable
//
// Build (first transaction after reset or any register write): clears the
// bitmap up to lim, then reads each sieve base up to sqrt(lim) and marks the
// multiples of each unmarked base. Test: each value from lower bound to lim
// (one bitmap RAM read each), plus the remainder unit for each prime found,
// one quotient bit per cycle. Stops at the first prime dividing the value.
// Synchronous active-high reset; the bitmap itself is not reset. The result
// strobe is not held off by the receiver; busy drops in the strobe cycle.
module sieve_trial_division_filter_top #(
   parameter int MAX_LIMIT = stdf_pkg::MAX_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [stdf_pkg::CANDIDATE_W-1:0]   req_candidate_value,
   output logic                               rsp_valid,
   output logic                               rsp_passes_filter,
   input  logic                               csr_write_enable,
   input  logic [stdf_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [stdf_pkg::CSR_DATA_W-1:0]    csr_write_data
);
   import stdf_pkg::*;

   localparam int DEPTH = MAX_LIMIT + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int LW    = (AW > CSR_DATA_W) ? AW : CSR_DATA_W;
   localparam int PW    = LW + 1;
   localparam int BW    = $clog2(CANDIDATE_W);
   localparam logic [LW-1:0] MAX_LW   = LW'(MAX_LIMIT);
   localparam logic [BW-1:0] BIT_LAST = BW'(CANDIDATE_W - 1);

   stdf_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0]  upper_ff, lower_ff;
   logic                   map_ready_ff, map_ready_in;
   logic [CANDIDATE_W-1:0] n_ff, n_in;
   logic [PW-1:0]          p_ff, p_in;
   logic [AW:0]            sq_ff, sq_in;
   logic [AW:0]            idx_ff, idx_in;
   logic [AW-1:0]          rem_ff, rem_in;
   logic [BW-1:0]          bit_ff, bit_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   pass_ff, pass_in;

   logic [LW-1:0] upper_ext;
   logic [LW-1:0] lim_lw;
   logic [AW-1:0] lim;
   logic [AW:0]   lim_x;
   logic [PW-1:0] lim_p;
   logic [PW-1:0] lo_eff;
   logic [PW-1:0] p_inc;
   logic [AW:0]   sq_step;
   logic [AW:0]   mark_next;
   logic [AW:0]   rem_shift;
   logic [AW:0]   divisor;
   logic [AW:0]   rem_next;

   logic          ram_wr_en, ram_rd_en;
   logic [AW-1:0] ram_wr_addr, ram_rd_addr;
   logic          ram_wr_data, ram_rd_data;

   stdf_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // effective bounds: divisors limited to MAX_LIMIT, never below two
   assign upper_ext = LW'(upper_ff);
   assign lim_lw    = (upper_ext > MAX_LW) ? MAX_LW : upper_ext;
   assign lim       = lim_lw[AW-1:0];
   assign lim_x     = {1'b0, lim};
   assign lim_p     = PW'(lim);
   assign lo_eff    = (lower_ff < MIN_DIVISOR) ? PW'(MIN_DIVISOR) : PW'(lower_ff);

   assign p_inc     = p_ff + 1'b1;
   // (p+1)^2 = p^2 + 2p + 1
   assign sq_step   = sq_ff + {p_ff[AW-1:0], 1'b1};
   assign mark_next = idx_ff + p_ff[AW:0];

   // restoring remainder, one dividend bit per cycle
   assign rem_shift = {rem_ff, n_ff[bit_ff]};
   assign divisor   = p_ff[AW:0];
   assign rem_next  = (rem_shift >= divisor) ? (rem_shift - divisor) : rem_shift;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         map_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         upper_ff     <= UPPER_BOUND_RESET;
         lower_ff     <= LOWER_BOUND_RESET;
      end else begin
         state_ff     <= state_in;
         map_ready_ff <= map_ready_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            case (csr_index)
               CSR_UPPER_BOUND: upper_ff <= csr_write_data;
               CSR_LOWER_BOUND: lower_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      p_ff    <= p_in;
      sq_ff   <= sq_in;
      idx_ff  <= idx_in;
      rem_ff  <= rem_in;
      bit_ff  <= bit_in;
      pass_ff <= pass_in;
   end

   always_comb begin
      state_in     = state_ff;
      map_ready_in = map_ready_ff;
      rsp_valid_in = 1'b0;
      pass_in      = pass_ff;
      n_in         = n_ff;
      p_in         = p_ff;
      sq_in        = sq_ff;
      idx_in       = idx_ff;
      rem_in       = rem_ff;
      bit_in       = bit_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = idx_ff[AW-1:0];
      ram_wr_data  = 1'b1;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = p_ff[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in = req_candidate_value;
               if (map_ready_ff) begin
                  p_in     = lo_eff;
                  state_in = ST_TEST_RD;
               end else begin
                  idx_in   = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            // 0 and 1 are marked so they never count as primes
            ram_wr_en   = 1'b1;
            ram_wr_data = (idx_ff < (AW+1)'(MIN_DIVISOR));
            if (idx_ff[AW-1:0] == lim) begin
               p_in     = PW'(MIN_DIVISOR);
               sq_in    = (AW+1)'(4);
               state_in = ST_SIEVE_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_SIEVE_RD: begin
            if (sq_ff > lim_x) begin
               map_ready_in = 1'b1;
               p_in         = lo_eff;
               state_in     = ST_TEST_RD;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_SIEVE_CHK;
            end
         end
         ST_SIEVE_CHK: begin
            if (ram_rd_data) begin
               p_in     = p_inc;
               sq_in    = sq_step;
               state_in = ST_SIEVE_RD;
            end else begin
               idx_in   = sq_ff;
               state_in = ST_MARK;
            end
         end
         ST_MARK: begin
            ram_wr_en = 1'b1;
            idx_in    = mark_next;
            if (mark_next > lim_x) begin
               p_in     = p_inc;
               sq_in    = sq_step;
               state_in = ST_SIEVE_RD;
            end
         end
         ST_TEST_RD: begin
            if (p_ff > lim_p) begin
               pass_in      = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_TEST_CHK;
            end
         end
         ST_TEST_CHK: begin
            if (ram_rd_data) begin
               p_in     = p_inc;
               state_in = ST_TEST_RD;
            end else begin
               rem_in   = '0;
               bit_in   = BIT_LAST;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = rem_next[AW-1:0];
            bit_in = bit_ff - 1'b1;
            if (bit_ff == '0) begin
               if (rem_next == '0) begin
                  pass_in      = 1'b0;
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  p_in     = p_inc;
                  state_in = ST_TEST_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // any register write invalidates the bitmap
      if (csr_write_enable &&
          (csr_index == CSR_UPPER_BOUND || csr_index == CSR_LOWER_BOUND)) begin
         map_ready_in = 1'b0;
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_passes_filter = pass_ff;

   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not start work");

   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy && $past(busy))
      else $error("result strobe without preceding work");

   a_write_only_build: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_MARK))
      else $error("bitmap written outside sieve build");

   a_test_needs_map: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST_CHK || state_ff == ST_DIV) |-> map_ready_ff)
      else $error("divisor test with stale bitmap");

   a_mark_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MARK |-> idx_ff <= lim_x)
      else $error("sieve mark beyond limit");

endmodule
